/* rtl/m65cd_pkg.sv */
// ----------------------------------------------------------------------------
// m65cd_pkg
// Shared types, constants and modulo-65521 helpers for the check digit codec.
// ----------------------------------------------------------------------------
package m65cd_pkg;

    // modulus, 17 bits wide to match the 17-bit check value arithmetic
    localparam logic [16:0] MODULUS    = 17'd65521;
    localparam logic [17:0] MODULUS_X2 = 18'd131042;
    // 100000 mod 65521
    localparam logic [15:0] SCALE_RED  = 16'd34479;
    // number of decimal check digits
    localparam int          TAIL_LEN   = 5;
    localparam logic [2:0]  COUNT_SAT  = 3'd6;
    localparam logic [2:0]  LAST_DIGIT = 3'(TAIL_LEN - 1);
    localparam logic [3:0]  DEC_MAX    = 4'd9;

    // what a processed item asks of the result side
    typedef enum logic [1:0] {
        K_ECHO,
        K_NONE,
        K_GEN_FINAL,
        K_VERDICT
    } t_kind;

    // descriptor handed from the core to the result sequencer
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  sym;
        logic [15:0] rem;
        logic [16:0] back;
        logic        pre;
    } t_desc;

    // reduce a 20-bit value mod 65521 (2^16 = 15 mod 65521)
    function automatic logic [15:0] m65cd_fold20(input logic [19:0] x);
        logic [16:0] y;
        y = 17'(x[15:0]) + 17'({x[19:16], 4'b0000}) - 17'(x[19:16]);
        if (y >= MODULUS) begin
            y = y - MODULUS;
        end
        return y[15:0];
    endfunction

    // reduce a 32-bit value mod 65521 in two folds
    function automatic logic [15:0] m65cd_reduce32(input logic [31:0] p);
        logic [19:0] y;
        y = 20'(p[15:0]) + 20'({p[31:16], 4'b0000}) - 20'(p[31:16]);
        return m65cd_fold20(y);
    endfunction

    // decimal place weight, most significant check digit first
    function automatic logic [16:0] m65cd_place(input logic [2:0] k);
        logic [16:0] w;
        unique case (k)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            3'd4:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/m65cd_if.sv */
// ----------------------------------------------------------------------------
// m65cd_if
// Valid/ready channels: message symbols in, result items out.
// ----------------------------------------------------------------------------
interface m65cd_sym_if;
    logic       valid;
    logic       ready;
    logic [3:0] symbol;
    logic       end_of_message;

    modport source (output valid, symbol, end_of_message, input ready);
    modport sink   (input valid, symbol, end_of_message, output ready);
endinterface

interface m65cd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_symbol;
    logic       is_check_digit;
    logic       verdict_valid;
    logic       last_result;

    modport source (output valid, out_symbol, is_check_digit, verdict_valid, last_result,
                    input ready);
    modport sink   (input valid, out_symbol, is_check_digit, verdict_valid, last_result,
                    output ready);
endinterface

/* rtl/mod65521_check_digit_codec.sv */
// ----------------------------------------------------------------------------
// mod65521_check_digit_codec
// Modulo-65521 check digit generator and checker with APB mode register.
// ----------------------------------------------------------------------------
// Symbols are taken one per clock cycle while the input is not stalled and pass
// through an input register, the remainder/tail update and a descriptor register
// before the result register, into which an echo is loaded from the descriptor
// register. In generate mode the final symbol's echo is loaded in the
// same cycle as a 16x16 multiply by 100000 mod 65521, then a reduction step
// follows and then one check digit per cycle while the output is free; the
// sequencer takes no descriptor until the fifth check digit is loaded, so the
// input stalls once the two registers in front fill. In check mode non-final
// symbols give no result; the verdict is loaded into the result register after
// the multiply and reduction steps, and the input stalls while each verdict is
// worked once the registers in front fill. The single result sequencer causes
// these stalls. Register 0 (check_mode, byte address 0) selects generate (0)
// or check (1); write it only while the block is idle.
module mod65521_check_digit_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m65cd_sym_if.sink   i_sym,
    m65cd_res_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register index bit of the byte address
    localparam logic CFG_IDX_MODE = 1'b0;

    logic             r_check_mode;
    logic             cfg_wr;
    logic             desc_valid;
    logic             desc_take;
    m65cd_pkg::t_desc desc;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MODE);
    assign prdata = (paddr[2] == CFG_IDX_MODE) ? {31'b0, r_check_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b0;
        end else if (cfg_wr) begin
            r_check_mode <= pwdata[0];
        end
    end

    // symbol intake and message state
    m65cd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sym        (i_sym),
        .i_check_mode (r_check_mode),
        .o_desc_valid (desc_valid),
        .o_desc       (desc),
        .i_desc_take  (desc_take)
    );

    // result sequencing
    m65cd_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc),
        .o_desc_take  (desc_take),
        .o_res        (o_res)
    );

endmodule

/* rtl/m65cd_core.sv */
// ----------------------------------------------------------------------------
// m65cd_core
// Input register, running remainder and tail state, descriptor register.
// ----------------------------------------------------------------------------
module m65cd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    m65cd_sym_if.sink           i_sym,
    input  logic                i_check_mode,
    output logic                o_desc_valid,
    output m65cd_pkg::t_desc    o_desc,
    input  logic                i_desc_take
);

    // input register
    logic       r_a_valid;
    logic [3:0] r_a_sym;
    logic       r_a_eom;
    logic       r_a_mode;

    // message state
    logic [15:0] r_rem;
    logic [3:0]  r_tail [m65cd_pkg::TAIL_LEN];
    logic [2:0]  r_count;
    logic        r_bad;

    // descriptor register
    logic               r_b_valid;
    m65cd_pkg::t_desc   r_desc;

    logic [15:0] n_rem;
    logic [15:0] upd_rem;
    logic [3:0]  n_tail [m65cd_pkg::TAIL_LEN];
    logic [2:0]  n_count;
    logic        n_bad;
    logic [17:0] back_sum;
    m65cd_pkg::t_desc n_desc;

    logic a_adv;
    logic a_fire;

    // handshake: item moves on when the descriptor slot is free or draining
    assign a_adv       = r_a_valid && (!r_b_valid || i_desc_take);
    assign i_sym.ready = !r_a_valid || a_adv;
    assign a_fire      = i_sym.valid && i_sym.ready;

    assign o_desc_valid = r_b_valid;
    assign o_desc       = r_desc;

    // state update for the item in the input register
    always_comb begin
        upd_rem  = r_rem;
        n_tail   = r_tail;
        n_count  = (r_count < m65cd_pkg::COUNT_SAT) ? r_count + 3'd1 : r_count;
        n_bad    = r_bad;
        back_sum = '0;

        n_desc.kind = m65cd_pkg::K_ECHO;
        n_desc.sym  = r_a_sym;
        n_desc.rem  = '0;
        n_desc.back = '0;
        n_desc.pre  = 1'b0;

        if (!r_a_mode) begin
            // generate: fold the symbol into the message number
            upd_rem     = m65cd_pkg::m65cd_fold20({r_rem, r_a_sym});
            n_desc.kind = r_a_eom ? m65cd_pkg::K_GEN_FINAL : m65cd_pkg::K_ECHO;
        end else begin
            // check: oldest tail digit joins the front once the tail is full
            if (r_count >= 3'(m65cd_pkg::TAIL_LEN)) begin
                upd_rem = m65cd_pkg::m65cd_fold20({r_rem, r_tail[0]});
            end
            for (int i = 0; i < m65cd_pkg::TAIL_LEN - 1; i++) begin
                n_tail[i] = r_tail[i + 1];
            end
            n_tail[m65cd_pkg::TAIL_LEN - 1] = r_a_sym;
            n_bad = 1'b0;
            for (int i = 0; i < m65cd_pkg::TAIL_LEN; i++) begin
                if (n_tail[i] > m65cd_pkg::DEC_MAX) begin
                    n_bad = 1'b1;
                end
                back_sum = back_sum + 18'(n_tail[i])
                         * 18'(m65cd_pkg::m65cd_place(3'(i)));
            end
            n_desc.kind = r_a_eom ? m65cd_pkg::K_VERDICT : m65cd_pkg::K_NONE;
            n_desc.back = back_sum[16:0];
            n_desc.pre  = (n_count >= m65cd_pkg::COUNT_SAT) && !n_bad;
        end
        n_desc.rem = upd_rem;

        // end of message clears the state
        n_rem = upd_rem;
        if (r_a_eom) begin
            n_rem   = '0;
            n_count = '0;
            n_bad   = 1'b0;
            for (int i = 0; i < m65cd_pkg::TAIL_LEN; i++) begin
                n_tail[i] = '0;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_rem     <= '0;
            r_count   <= '0;
            r_bad     <= 1'b0;
            for (int i = 0; i < m65cd_pkg::TAIL_LEN; i++) begin
                r_tail[i] <= '0;
            end
        end else begin
            if (a_fire) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
                r_rem     <= n_rem;
                r_count   <= n_count;
                r_bad     <= n_bad;
                r_tail    <= n_tail;
            end else if (i_desc_take) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_a_sym  <= i_sym.symbol;
            r_a_eom  <= i_sym.end_of_message;
            r_a_mode <= i_check_mode;
        end
        if (a_adv) begin
            r_desc <= n_desc;
        end
    end

endmodule

/* rtl/m65cd_emit.sv */
// ----------------------------------------------------------------------------
// m65cd_emit
// Result sequencer: echoes, check digit generation and verdicts.
// ----------------------------------------------------------------------------
module m65cd_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_desc_valid,
    input  m65cd_pkg::t_desc    i_desc,
    output logic                o_desc_take,
    m65cd_res_if.source         o_res
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_RED,
        ST_DIG,
        ST_VER
    } t_state;

    t_state      r_st,     n_st;
    logic [31:0] r_prod,   n_prod;
    logic        r_is_ver, n_is_ver;
    logic [16:0] r_back,   n_back;
    logic        r_pre,    n_pre;
    logic [16:0] r_val,    n_val;
    logic [2:0]  r_k,      n_k;

    logic        r_o_valid, n_o_valid;
    logic [3:0]  r_o_sym,   n_o_sym;
    logic        r_o_chk,   n_o_chk;
    logic        r_o_ver,   n_o_ver;
    logic        r_o_last,  n_o_last;

    logic        out_free;
    logic        load;
    logic [15:0] red_m;
    logic [16:0] place;
    logic [3:0]  dig;
    logic [16:0] sub;
    logic [17:0] ver_sum;

    assign out_free = !r_o_valid || o_res.ready;

    assign o_res.valid          = r_o_valid;
    assign o_res.out_symbol     = r_o_sym;
    assign o_res.is_check_digit = r_o_chk;
    assign o_res.verdict_valid  = r_o_ver;
    assign o_res.last_result    = r_o_last;

    // reduction of the registered product
    assign red_m = m65cd_pkg::m65cd_reduce32(r_prod);

    // one decimal digit by compare against the place multiples
    assign place = m65cd_pkg::m65cd_place(r_k);
    always_comb begin
        dig = '0;
        sub = '0;
        for (int j = 1; j < 10; j++) begin
            if (r_val >= 17'(j) * place) begin
                dig = 4'(j);
                sub = 17'(j) * place;
            end
        end
    end

    // front * 100000 + back divisible when the residue sum hits a multiple
    assign ver_sum = {1'b0, r_val} + {1'b0, r_back};

    // sequencer next state
    always_comb begin
        n_st      = r_st;
        n_prod    = r_prod;
        n_is_ver  = r_is_ver;
        n_back    = r_back;
        n_pre     = r_pre;
        n_val     = r_val;
        n_k       = r_k;
        n_o_sym   = r_o_sym;
        n_o_chk   = r_o_chk;
        n_o_ver   = r_o_ver;
        n_o_last  = r_o_last;
        load        = 1'b0;
        o_desc_take = 1'b0;

        unique case (r_st)
            ST_RUN: begin
                if (i_desc_valid && (i_desc.kind == m65cd_pkg::K_NONE || out_free)) begin
                    o_desc_take = 1'b1;
                    unique case (i_desc.kind)
                        m65cd_pkg::K_ECHO, m65cd_pkg::K_GEN_FINAL: begin
                            load     = 1'b1;
                            n_o_sym  = i_desc.sym;
                            n_o_chk  = 1'b0;
                            n_o_ver  = 1'b0;
                            n_o_last = 1'b0;
                        end
                        m65cd_pkg::K_NONE, m65cd_pkg::K_VERDICT: begin
                        end
                        default: begin
                        end
                    endcase
                    if (i_desc.kind == m65cd_pkg::K_GEN_FINAL
                        || i_desc.kind == m65cd_pkg::K_VERDICT) begin
                        n_prod   = 32'(i_desc.rem) * 32'(m65cd_pkg::SCALE_RED);
                        n_is_ver = (i_desc.kind == m65cd_pkg::K_VERDICT);
                        n_back   = i_desc.back;
                        n_pre    = i_desc.pre;
                        n_st     = ST_RED;
                    end
                end
            end
            ST_RED: begin
                n_k = '0;
                if (r_is_ver) begin
                    n_val = {1'b0, red_m};
                    n_st  = ST_VER;
                end else begin
                    n_val = m65cd_pkg::MODULUS - {1'b0, red_m};
                    n_st  = ST_DIG;
                end
            end
            ST_DIG: begin
                if (out_free) begin
                    load     = 1'b1;
                    n_o_sym  = dig;
                    n_o_chk  = 1'b1;
                    n_o_ver  = 1'b0;
                    n_o_last = (r_k == m65cd_pkg::LAST_DIGIT);
                    n_val    = r_val - sub;
                    n_k      = r_k + 3'd1;
                    if (r_k == m65cd_pkg::LAST_DIGIT) begin
                        n_st = ST_RUN;
                    end
                end
            end
            ST_VER: begin
                if (out_free) begin
                    load     = 1'b1;
                    n_o_sym  = '0;
                    n_o_chk  = 1'b0;
                    n_o_ver  = r_pre && (ver_sum == 18'd0
                               || ver_sum == 18'(m65cd_pkg::MODULUS)
                               || ver_sum == m65cd_pkg::MODULUS_X2);
                    n_o_last = 1'b1;
                    n_st     = ST_RUN;
                end
            end
            default: begin
                n_st = ST_RUN;
            end
        endcase

        n_o_valid = load ? 1'b1 : (o_res.ready ? 1'b0 : r_o_valid);
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_RUN;
            r_o_valid <= 1'b0;
            r_k       <= '0;
        end else begin
            r_st      <= n_st;
            r_o_valid <= n_o_valid;
            r_k       <= n_k;
        end
        r_prod   <= n_prod;
        r_is_ver <= n_is_ver;
        r_back   <= n_back;
        r_pre    <= n_pre;
        r_val    <= n_val;
        r_o_sym  <= n_o_sym;
        r_o_chk  <= n_o_chk;
        r_o_ver  <= n_o_ver;
        r_o_last <= n_o_last;
    end

`ifndef SYNTHESIS
    // reduction always hands over to digits or verdict
    a_red_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RED) |=> (r_st == ST_DIG || r_st == ST_VER))
        else $error("reduction step not followed by digit or verdict step");

    // the fifth check digit ends the digit run
    a_dig_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIG && load && r_k == m65cd_pkg::LAST_DIGIT) |=> (r_st == ST_RUN))
        else $error("digit run did not end after the fifth digit");

    // a check digit never carries a verdict
    a_chk_ver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_chk && r_o_ver))
        else $error("check digit result with verdict set");

    // no descriptor is taken while a final item is still being worked
    a_take_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_RUN) |-> !o_desc_take)
        else $error("descriptor taken outside the run state");

    // the digit counter stays within the five places
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIG) |-> (r_k <= m65cd_pkg::LAST_DIGIT))
        else $error("digit counter out of range");
`endif

endmodule
